@@ rtl/spwm_pkg.sv @@
// spwm_pkg: shared types and fixed widths for the three-phase sine pwm unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps

package spwm_pkg;

   // fixed field widths
   localparam int TIDX_W  = 6;   // table index field
   localparam int SINE_W  = 8;   // sine table entry
   localparam int AMP_W   = 8;   // amplitude register
   localparam int DEAD_W  = 7;   // dead time register
   localparam int DUTY_W  = 8;   // duty per phase
   localparam int SLOT_W  = 8;   // slot counter
   localparam int SW_W    = 8;   // switch-over countdown
   localparam int PHASES  = 3;

   // switch countdown code for no switch pending
   localparam logic [SW_W-1:0] SW_IDLE = '1;

   // register map, one 32-bit word each
   typedef enum logic {
      REG_AMPLITUDE,
      REG_DEAD_SLOTS
   } csr_reg_type;

   // control for one processed beat
   typedef struct packed {
      logic fire;      // item leaves the input register this cycle
      logic write;     // table write instead of slot tick
      logic advance;   // step phases before the slot
      logic go;        // bridges running
   } step_ctl_type;

   typedef logic [PHASES-1:0][DUTY_W-1:0] duty_vec_type;

   // pin state shown for one slot tick
   typedef struct packed {
      logic [PHASES-1:0] en;
      logic [PHASES-1:0] high;
      logic              cycle_start;
   } pins_type;

endpackage

@@ rtl/spwm_sine_mem.sv @@
// spwm_sine_mem: one copy of the sine table, one write and one registered read port
// read data bypasses a write to the same address in the same cycle; uses spwm_pkg
`timescale 1ns / 1ps

module spwm_sine_mem #(
   parameter int DEPTH = 36,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [spwm_pkg::SINE_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [spwm_pkg::SINE_W-1:0] rd_data
);
   import spwm_pkg::*;

   logic [SINE_W-1:0] mem [DEPTH];
   logic [SINE_W-1:0] rd_data_ff;

   // table write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, write-first on the same address
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/spwm_phase.sv @@
// spwm_phase: phase index, sine table copy and duty computation for one bridge
// depends on spwm_pkg and spwm_sine_mem
`timescale 1ns / 1ps

module spwm_phase #(
   parameter int TABLE_SIZE  = 36,
   parameter int SLOTS       = 64,
   parameter int RESET_INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spwm_pkg::step_ctl_type           ctl,
   input  logic [spwm_pkg::TIDX_W-1:0]      wr_index,
   input  logic [spwm_pkg::SINE_W-1:0]      wr_value,
   input  logic [spwm_pkg::AMP_W-1:0]       amplitude,
   output logic [spwm_pkg::DUTY_W-1:0]      duty
);
   import spwm_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] RST_IDX = IDX_W'(RESET_INDEX);
   localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(SLOTS - 3);

   logic [IDX_W-1:0]        phase_ff;
   logic [IDX_W-1:0]        phase_in;
   logic [IDX_W-1:0]        phase_sel;
   logic [DUTY_W-1:0]       duty_ff;
   logic [DUTY_W-1:0]       duty_in;
   logic [DUTY_W-1:0]       duty_calc;
   logic [SINE_W-1:0]       sine;
   logic [SINE_W+AMP_W-1:0] product;
   logic                    step_adv;
   logic                    wr_en;

   // wrap to zero at the table end
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W:0] sum;
      sum = {1'b0, idx} + 1'b1;
      if (sum >= (IDX_W + 1)'(TABLE_SIZE)) begin
         return '0;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign step_adv = ctl.fire && !ctl.write && ctl.advance;
   assign wr_en    = ctl.fire && ctl.write &&
                     ({1'b0, wr_index} < (TIDX_W + 1)'(TABLE_SIZE));

   // phase stepping; the table copy always holds the entry after the phase
   assign phase_in  = step_adv ? next_index(phase_ff) : phase_ff;
   assign phase_sel = reset ? RST_IDX : phase_in;

   spwm_sine_mem #(
      .DEPTH (TABLE_SIZE),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index[IDX_W-1:0]),
      .wr_data (wr_value),
      .rd_addr (next_index(phase_sel)),
      .rd_data (sine)
   );

   // scaled sine, clamped below the slot count
   assign product   = {{AMP_W{1'b0}}, sine} * {{SINE_W{1'b0}}, amplitude};
   assign duty_calc = (product[SINE_W+AMP_W-1:8] > DUTY_MAX) ? DUTY_MAX
                                                             : product[SINE_W+AMP_W-1:8];
   assign duty_in   = step_adv ? duty_calc : duty_ff;
   assign duty      = duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RST_IDX;
         duty_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         duty_ff  <= duty_in;
      end
   end

endmodule

@@ rtl/spwm_bridge.sv @@
// spwm_bridge: pwm cycle timing, dead time and bridge pin latch for all three phases
// depends on spwm_pkg
`timescale 1ns / 1ps

module spwm_bridge #(
   parameter int SLOTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spwm_pkg::step_ctl_type       ctl,
   input  logic [spwm_pkg::DEAD_W-1:0]  dead_slots,
   input  spwm_pkg::duty_vec_type       duty,
   output spwm_pkg::pins_type           pins
);
   import spwm_pkg::*;

   logic [SLOT_W-1:0]             slot_ff, slot_in, slot_next;
   logic [DEAD_W-1:0]             dcount_ff, dcount_in;
   logic                          in_dead_ff, in_dead_in;
   logic [PHASES-1:0]             pending_ff, pending_in;
   logic [PHASES-1:0][SW_W-1:0]   sw_ff, sw_in, sw_work;
   logic [PHASES-1:0]             en_ff, en_in, en_work;
   logic [PHASES-1:0]             high_ff, high_in, high_work;

   always_comb begin
      slot_in    = slot_ff;
      dcount_in  = dcount_ff;
      in_dead_in = in_dead_ff;
      pending_in = pending_ff;
      sw_in      = sw_ff;
      en_in      = en_ff;
      high_in    = high_ff;
      en_work    = en_ff;
      high_work  = high_ff;
      sw_work    = sw_ff;
      slot_next  = slot_ff + 1'b1;
      pins       = '0;
      if (ctl.fire && !ctl.write) begin
         if (!ctl.go) begin
            // stopped: all off, cycle restarts
            en_in      = '0;
            high_in    = '0;
            in_dead_in = 1'b1;
            dcount_in  = '0;
            slot_in    = '0;
            pending_in = '1;
            sw_in      = {PHASES{SW_IDLE}};
         end else begin
            pins.cycle_start = in_dead_ff && (dcount_ff == '0);
            if (in_dead_ff && (dcount_ff < dead_slots)) begin
               // leading dead time
               en_in     = '0;
               dcount_in = dcount_ff + 1'b1;
               pins.en   = '0;
               pins.high = high_ff;
            end else begin
               // dead time over: all high and enabled
               if (in_dead_ff) begin
                  en_work    = '1;
                  high_work  = '1;
                  in_dead_in = 1'b0;
               end
               // duty reached or passed: disable and start the switch countdown
               for (int p = 0; p < PHASES; p++) begin
                  if ((slot_ff == duty[p]) || ((slot_ff > duty[p]) && pending_ff[p])) begin
                     en_work[p]    = 1'b0;
                     pending_in[p] = 1'b0;
                     sw_work[p]    = {1'b0, dead_slots};
                  end
               end
               pins.en   = en_work;
               pins.high = high_work;
               // countdown done: low side, enabled
               for (int p = 0; p < PHASES; p++) begin
                  if (sw_work[p] == '0) begin
                     high_work[p] = 1'b0;
                     en_work[p]   = 1'b1;
                     sw_work[p]   = SW_IDLE;
                  end else if (sw_work[p] != SW_IDLE) begin
                     sw_work[p] = sw_work[p] - 1'b1;
                  end
               end
               en_in   = en_work;
               high_in = high_work;
               sw_in   = sw_work;
               // last slot ends the cycle
               if (slot_next >= SLOT_W'(SLOTS)) begin
                  slot_in    = '0;
                  in_dead_in = 1'b1;
                  dcount_in  = '0;
                  pending_in = '1;
                  sw_in      = {PHASES{SW_IDLE}};
               end else begin
                  slot_in = slot_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         dcount_ff  <= '0;
         in_dead_ff <= 1'b1;
         pending_ff <= '1;
         sw_ff      <= {PHASES{SW_IDLE}};
         en_ff      <= '0;
         high_ff    <= '0;
      end else begin
         slot_ff    <= slot_in;
         dcount_ff  <= dcount_in;
         in_dead_ff <= in_dead_in;
         pending_ff <= pending_in;
         sw_ff      <= sw_in;
         en_ff      <= en_in;
         high_ff    <= high_in;
      end
   end

endmodule

@@ rtl/three_phase_sine_pwm_dead_time_unit.sv @@
// three_phase_sine_pwm_dead_time_unit: top level with handshake registers and csr port
// depends on spwm_pkg, spwm_phase and spwm_bridge
`timescale 1ns / 1ps

// Three-phase sine pwm with dead time.
// Request channel (req_*): one beat is either a slot tick (req_cmd 0) or a sine
// table write (req_cmd 1, req_table_index / req_table_value). A slot tick with
// req_advance set steps all three phases and recomputes their duties first;
// req_go low forces all pins off and restarts the pwm cycle.
// Response channel (rsp_*): one beat per slot tick with the six bridge lines
// and cycle_start; a table write gives no response beat.
// Timing: a beat is processed when it leaves the input register, and its
// response is registered. Throughput is one beat per cycle while the response
// side is not stalled, set by the single pass from input register to response
// register. A stalled response holds its register; the input register still
// takes one more beat, and req_ready drops only while both are full.
// CSR: amplitude at 0x0, dead_slots at 0x4, written on the APB access phase.
// Reset clears all control state, amplitude to 0 and dead_slots to 4; the
// sine table is not cleared and must be written before it is used.
module three_phase_sine_pwm_dead_time_unit #(
   parameter int TABLE_SIZE = 36,
   parameter int SLOTS      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic                          req_advance,
   input  logic                          req_go,
   input  logic [spwm_pkg::TIDX_W-1:0]   req_table_index,
   input  logic [spwm_pkg::SINE_W-1:0]   req_table_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_u_enable,
   output logic                          rsp_u_high,
   output logic                          rsp_v_enable,
   output logic                          rsp_v_high,
   output logic                          rsp_w_enable,
   output logic                          rsp_w_high,
   output logic                          rsp_cycle_start,
   // csr port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import spwm_pkg::*;

   localparam int IDX_V = (2 * TABLE_SIZE) / 3;
   localparam int IDX_W = TABLE_SIZE / 3;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff, s1_advance_ff, s1_go_ff;
   logic [TIDX_W-1:0]  s1_index_ff;
   logic [SINE_W-1:0]  s1_value_ff;
   logic               fire;
   logic               take;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   pins_type           pins;
   pins_type           rsp_pins_ff;

   // csr registers
   logic [AMP_W-1:0]   amplitude_ff;
   logic [DEAD_W-1:0]  dead_slots_ff;
   logic               csr_wr;

   step_ctl_type       ctl;
   duty_vec_type       duty;

   // handshake
   assign fire        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || fire;
   assign take        = req_valid && req_ready;
   assign s1_valid_in = take || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire ? !s1_cmd_ff : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input beat payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff     <= req_cmd;
         s1_advance_ff <= req_advance;
         s1_go_ff      <= req_go;
         s1_index_ff   <= req_table_index;
         s1_value_ff   <= req_table_value;
      end
   end

   // response beat payload
   always_ff @(posedge clock) begin
      if (fire && !s1_cmd_ff) begin
         rsp_pins_ff <= pins;
      end
   end

   assign ctl.fire    = fire;
   assign ctl.write   = s1_cmd_ff;
   assign ctl.advance = s1_advance_ff;
   assign ctl.go      = s1_go_ff;

   // per-phase index, table and duty
   spwm_phase #(
      .TABLE_SIZE (TABLE_SIZE),
      .SLOTS      (SLOTS),
      .RESET_INDEX(0)
   ) u_phase_u (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_index  (s1_index_ff),
      .wr_value  (s1_value_ff),
      .amplitude (amplitude_ff),
      .duty      (duty[0])
   );

   spwm_phase #(
      .TABLE_SIZE (TABLE_SIZE),
      .SLOTS      (SLOTS),
      .RESET_INDEX(IDX_V)
   ) u_phase_v (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_index  (s1_index_ff),
      .wr_value  (s1_value_ff),
      .amplitude (amplitude_ff),
      .duty      (duty[1])
   );

   spwm_phase #(
      .TABLE_SIZE (TABLE_SIZE),
      .SLOTS      (SLOTS),
      .RESET_INDEX(IDX_W)
   ) u_phase_w (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_index  (s1_index_ff),
      .wr_value  (s1_value_ff),
      .amplitude (amplitude_ff),
      .duty      (duty[2])
   );

   // cycle timing and pin latch
   spwm_bridge #(
      .SLOTS (SLOTS)
   ) u_bridge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .dead_slots (dead_slots_ff),
      .duty       (duty),
      .pins       (pins)
   );

   // csr write on the access phase
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff  <= '0;
         dead_slots_ff <= DEAD_W'(4);
      end else if (csr_wr) begin
         case (csr_reg_type'(paddr[2]))
            REG_AMPLITUDE:  amplitude_ff  <= pwdata[AMP_W-1:0];
            REG_DEAD_SLOTS: dead_slots_ff <= pwdata[DEAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // csr read back
   always_comb begin
      case (csr_reg_type'(paddr[2]))
         REG_AMPLITUDE:  prdata = {{(32 - AMP_W){1'b0}}, amplitude_ff};
         REG_DEAD_SLOTS: prdata = {{(32 - DEAD_W){1'b0}}, dead_slots_ff};
         default:        prdata = '0;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_u_enable    = rsp_pins_ff.en[0];
   assign rsp_u_high      = rsp_pins_ff.high[0];
   assign rsp_v_enable    = rsp_pins_ff.en[1];
   assign rsp_v_high      = rsp_pins_ff.high[1];
   assign rsp_w_enable    = rsp_pins_ff.en[2];
   assign rsp_w_high      = rsp_pins_ff.high[2];
   assign rsp_cycle_start = rsp_pins_ff.cycle_start;

endmodule

@@ rtl/spwm_checker.sv @@
// spwm_checker: port-level assertions for the three-phase sine pwm unit
// bound to three_phase_sine_pwm_dead_time_unit; depends on spwm_pkg
`timescale 1ns / 1ps

module spwm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_u_enable,
   input logic                          rsp_u_high,
   input logic                          rsp_v_enable,
   input logic                          rsp_v_high,
   input logic                          rsp_w_enable,
   input logic                          rsp_w_high,
   input logic                          rsp_cycle_start,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [2:0]                    paddr,
   input logic [31:0]                   pwdata,
   input logic [31:0]                   prdata,
   input logic                          pready
);
   import spwm_pkg::*;

   logic [6:0] rsp_bits;

   assign rsp_bits = {rsp_u_enable, rsp_u_high, rsp_v_enable, rsp_v_high,
                      rsp_w_enable, rsp_w_high, rsp_cycle_start};

   // no response beat straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
      else $error("stalled response beat changed");

   // request side stalls only while the response side is full and stalled
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response backpressure");

   // amplitude write reads back
   a_amp_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata[AMP_W-1:0] == $past(pwdata[AMP_W-1:0]))
      else $error("amplitude read back mismatch");

   // dead time write reads back
   a_dead_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[2]) ##1 paddr[2]
      |-> prdata[DEAD_W-1:0] == $past(pwdata[DEAD_W-1:0]))
      else $error("dead_slots read back mismatch");

endmodule

bind three_phase_sine_pwm_dead_time_unit spwm_checker u_spwm_checker (.*);
